[src/usx_pkg.sv]
// shared types, constants and the keystream step for the udp payload scrambler
// no dependencies; imported by every module of the block
package usx_pkg;

	localparam int unsigned POS_W      = 17;
	localparam int unsigned SEED_W     = 64;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_CSUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IPV6_EN   = 2'd2;

	localparam logic [3:0] IP_V4     = 4'd4;
	localparam logic [3:0] IP_V6     = 4'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [POS_W-1:0] HDR_V4       = 17'd20;
	localparam logic [POS_W-1:0] HDR_V6       = 17'd40;
	localparam logic [POS_W-1:0] PROTO_OFF_V4 = 17'd9;
	localparam logic [POS_W-1:0] PROTO_OFF_V6 = 17'd6;

	// offsets inside the udp header
	localparam logic [POS_W-1:0] UDP_LEN_HI  = 17'd4;
	localparam logic [POS_W-1:0] UDP_LEN_LO  = 17'd5;
	localparam logic [POS_W-1:0] UDP_CSUM_HI = 17'd6;
	localparam logic [POS_W-1:0] UDP_CSUM_LO = 17'd7;
	localparam logic [POS_W-1:0] UDP_HDR_LEN = 17'd8;

	localparam int unsigned XS_A = 13;
	localparam int unsigned XS_B = 7;
	localparam int unsigned XS_C = 17;

	typedef enum logic [1:0] {
		VERDICT_SCRAMBLED   = 2'd0,
		VERDICT_NOT_UDP     = 2'd1,
		VERDICT_BAD_VERSION = 2'd2,
		VERDICT_TRUNCATED   = 2'd3
	} verdict_t;

	// one classified byte, handed from the front to the back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		verdict_t   verdict;
		logic       restart;
		logic       advance;
		logic       xor_en;
		logic       zero_en;
		logic [2:0] lane;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [SEED_W-1:0] xs_advance(input logic [SEED_W-1:0] x);
		logic [SEED_W-1:0] a;
		logic [SEED_W-1:0] b;
		a = x ^ (x << XS_A);
		b = a ^ (a >> XS_B);
		return b ^ (b << XS_C);
	endfunction

endpackage

[src/usx_if.sv]
// valid/ready channel interfaces for packet bytes in and scrambled bytes out
// no dependencies
interface usx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source(output valid, data_byte, first_byte, last_byte, input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface usx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic [1:0] verdict;

	modport source(output valid, out_byte, out_last, verdict, input ready);
	modport sink(input valid, out_byte, out_last, verdict, output ready);
endinterface

[src/usx_front.sv]
// header parser: tracks byte position and captured header fields, classifies each item
// depends on usx_pkg and usx_in_if
module usx_front
	import usx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	usx_in_if.sink       in_ch,
	input  logic         ipv6_enable,
	input  logic         zero_checksum,
	input  q_stat_t      q_stat,
	output logic         push_valid,
	output op_t          push_op
);

	logic [POS_W-1:0] pos_q;
	logic [3:0]       ver_q;
	logic [7:0]       proto_q;
	logic [15:0]      len_q;

	logic [POS_W-1:0] pos;
	logic             pos0;
	logic [3:0]       ver;
	logic             ver_ok;
	logic [POS_W-1:0] hdr;
	logic [POS_W-1:0] proto_off;
	logic [POS_W-1:0] rel;
	logic [7:0]       proto_old;
	logic [7:0]       proto_new;
	logic [15:0]      len_old;
	logic [15:0]      len_new;
	logic             xor_en;
	logic             zero_en;
	logic             advance;
	logic [POS_W:0]   count;
	logic [POS_W:0]   need;
	verdict_t         verdict;
	logic             accept;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && !q_stat.full;
	assign push_valid  = accept;

	always_comb begin
		pos       = in_ch.first_byte ? '0 : pos_q;
		pos0      = (pos == '0);
		ver       = pos0 ? in_ch.data_byte[7:4] : ver_q;
		ver_ok    = (ver == IP_V4) || ((ver == IP_V6) && ipv6_enable);
		hdr       = (ver == IP_V4) ? HDR_V4 : HDR_V6;
		proto_off = (ver == IP_V4) ? PROTO_OFF_V4 : PROTO_OFF_V6;
		rel       = pos - hdr;
		proto_old = pos0 ? 8'd0 : proto_q;
		len_old   = pos0 ? 16'd0 : len_q;
		proto_new = proto_old;
		len_new   = len_old;
		xor_en    = 1'b0;
		zero_en   = 1'b0;
		advance   = 1'b0;
		if (ver_ok) begin
			if (pos == proto_off) begin
				proto_new = in_ch.data_byte;
			end
			if ((proto_new == PROTO_UDP) && (pos >= hdr)) begin
				if (rel == UDP_LEN_HI) begin
					len_new = {in_ch.data_byte, len_old[7:0]};
				end else if (rel == UDP_LEN_LO) begin
					len_new = {len_old[15:8], in_ch.data_byte};
				end else if ((rel == UDP_CSUM_HI) || (rel == UDP_CSUM_LO)) begin
					zero_en = zero_checksum && ({1'b0, len_old} >= UDP_HDR_LEN);
				end else if ((rel >= UDP_HDR_LEN) && (rel < {1'b0, len_old})) begin
					xor_en  = 1'b1;
					advance = (rel[2:0] == 3'd0);
				end
			end
		end

		count = {1'b0, pos} + 18'd1;
		need  = {1'b0, hdr} + {2'b00, len_new};
		if (!ver_ok) begin
			verdict = VERDICT_BAD_VERSION;
		end else if (pos < proto_off) begin
			verdict = VERDICT_TRUNCATED;
		end else if (proto_new != PROTO_UDP) begin
			verdict = VERDICT_NOT_UDP;
		end else if (({1'b0, len_new} < UDP_HDR_LEN) || (count < need)) begin
			verdict = VERDICT_TRUNCATED;
		end else begin
			verdict = VERDICT_SCRAMBLED;
		end

		push_op.data    = in_ch.data_byte;
		push_op.last    = in_ch.last_byte;
		push_op.verdict = in_ch.last_byte ? verdict : VERDICT_SCRAMBLED;
		push_op.restart = pos0;
		push_op.advance = advance;
		push_op.xor_en  = xor_en;
		push_op.zero_en = zero_en;
		push_op.lane    = rel[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ver_q   <= '0;
			proto_q <= '0;
			len_q   <= '0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				pos_q <= '0;
			end else if (pos < POS_MAX) begin
				pos_q <= pos + 17'd1;
			end else begin
				pos_q <= pos;
			end
			ver_q   <= ver;
			proto_q <= proto_new;
			len_q   <= len_new;
		end
	end

endmodule

[src/usx_queue.sv]
// short fifo of classified bytes between the parser and the keystream unit
// depends on usx_pkg
module usx_queue
	import usx_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  op_t     push_op,
	input  logic    pop,
	output op_t     pop_op,
	output q_stat_t q_stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	op_t              slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_op       = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/usx_back.sv]
// keystream unit: runs the xorshift generator, applies xor or zeroing, output register
// depends on usx_pkg and usx_out_if
module usx_back
	import usx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SEED_W-1:0] seed,
	input  q_stat_t           q_stat,
	input  op_t               pop_op,
	output logic              pop,
	usx_out_if.source         out_ch
);

	logic [SEED_W-1:0] word_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	verdict_t          verdict_q;

	logic [SEED_W-1:0] base;
	logic [SEED_W-1:0] word_nxt;
	logic [7:0]        ks_byte;
	logic [7:0]        res_byte;

	assign pop = !q_stat.empty && (!out_valid_q || out_ch.ready);

	always_comb begin
		base     = pop_op.restart ? seed : word_q;
		word_nxt = pop_op.advance ? xs_advance(base) : base;
		ks_byte  = word_nxt[{pop_op.lane, 3'b000} +: 8];
		if (pop_op.zero_en) begin
			res_byte = 8'd0;
		end else if (pop_op.xor_en) begin
			res_byte = pop_op.data ^ ks_byte;
		end else begin
			res_byte = pop_op.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				word_q      <= word_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= res_byte;
			out_last_q <= pop_op.last;
			verdict_q  <= pop_op.verdict;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.out_last = out_last_q;
	assign out_ch.verdict  = verdict_q;

endmodule

[src/udp_payload_xorshift_scrambler_core.sv]
// an accepted item is written into the queue, then moved into the output register of the
// keystream unit, from which it is presented on the output
// throughput: one item per cycle sustained while out_ch.ready holds; the xorshift step
// and byte xor are combinational in the keystream unit, the header parser in the front
// the byte queue between them lets either side stall for QUEUE_DEPTH items
// reset (arst_n low, asynchronous): position and header fields cleared, queue emptied,
// seed and zero_checksum cleared, ipv6_enable set; no clearing pass, ready right after reset
module udp_payload_xorshift_scrambler_core
	import usx_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	usx_in_if.sink                in_ch,
	usx_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	logic [SEED_W-1:0] seed_q;
	logic              zero_csum_q;
	logic              ipv6_en_q;

	// front to queue and queue to back
	logic    push;
	op_t     push_op;
	logic    pop;
	op_t     pop_op;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			zero_csum_q <= 1'b0;
			ipv6_en_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED:      seed_q      <= cfg_wdata[SEED_W-1:0];
				REG_ZERO_CSUM: zero_csum_q <= cfg_wdata[0];
				REG_IPV6_EN:   ipv6_en_q   <= cfg_wdata[0];
				default:       ; // unmapped index, write dropped
			endcase
		end
	end

	// header parser: version, protocol and udp length capture, per-byte classification
	usx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.ipv6_enable   (ipv6_en_q),
		.zero_checksum (zero_csum_q),
		.q_stat        (q_stat),
		.push_valid    (push),
		.push_op       (push_op)
	);

	// decoupling queue of classified bytes
	usx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.q_stat  (q_stat)
	);

	// keystream generator and output register; the seed is loaded on the first byte
	usx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.seed   (seed_q),
		.q_stat (q_stat),
		.pop_op (pop_op),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// a verdict other than scrambled only travels with the last byte of a packet
	a_verdict_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.out_last) |-> (out_ch.verdict == VERDICT_SCRAMBLED))
		else $error("verdict set on a byte that is not last");

	// an accepted item is held either in the queue or in the output register
	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (!q_stat.empty || out_ch.valid))
		else $error("accepted item lost");

	// queue occupancy flags never contradict
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

endmodule
